/* src/sv39ptw_pkg.sv */
// ----------------------------------------------------------------------------
// sv39ptw_pkg
// shared constants, control word layout and microcode rom of the page walker
// ----------------------------------------------------------------------------
`default_nettype none

package sv39ptw_pkg;

    localparam int SV39PTW_STORE_PAGES = 64;
    localparam int ENTRIES_PER_TABLE   = 512;
    localparam int IDX_W               = 9;
    localparam int ENTRY_W             = 64;
    localparam int PPN_W               = 44;
    localparam int VA_W                = 39;
    localparam int FREE_W              = 7;

    // result status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_NOT_MAPPED = 2'd1;
    localparam logic [1:0] STAT_NO_PAGES   = 2'd2;

    // micro-operations
    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_CLEAR   = 4'd1;
    localparam logic [3:0] OP_TAKE    = 4'd2;
    localparam logic [3:0] OP_ROOT    = 4'd3;
    localparam logic [3:0] OP_READ    = 4'd4;
    localparam logic [3:0] OP_ALLOC   = 4'd5;
    localparam logic [3:0] OP_ZERO    = 4'd6;
    localparam logic [3:0] OP_LINK    = 4'd7;
    localparam logic [3:0] OP_DESCEND = 4'd8;
    localparam logic [3:0] OP_SET_OK  = 4'd9;
    localparam logic [3:0] OP_WLEAF   = 4'd10;
    localparam logic [3:0] OP_SET_NM  = 4'd11;
    localparam logic [3:0] OP_SET_OOP = 4'd12;
    localparam logic [3:0] OP_POST    = 4'd13;

    // jump conditions
    localparam logic [3:0] C_NEXT      = 4'd0;
    localparam logic [3:0] C_ALWAYS    = 4'd1;
    localparam logic [3:0] C_CLR_BUSY  = 4'd2;
    localparam logic [3:0] C_NO_TAKE   = 4'd3;
    localparam logic [3:0] C_ROOT_BAD  = 4'd4;
    localparam logic [3:0] C_ENTRY_V   = 4'd5;
    localparam logic [3:0] C_LOOKUP    = 4'd6;
    localparam logic [3:0] C_NO_FREE   = 4'd7;
    localparam logic [3:0] C_ZERO_BUSY = 4'd8;
    localparam logic [3:0] C_PTR_BAD   = 4'd9;
    localparam logic [3:0] C_MORE_LVL  = 4'd10;
    localparam logic [3:0] C_IS_MAP    = 4'd11;
    localparam logic [3:0] C_ENTRY_INV = 4'd12;
    localparam logic [3:0] C_OUT_FREE  = 4'd13;

    // program steps
    localparam logic [4:0] ST_CLEAR    = 5'd0;
    localparam logic [4:0] ST_IDLE     = 5'd1;
    localparam logic [4:0] ST_ROOT     = 5'd2;
    localparam logic [4:0] ST_READ     = 5'd3;
    localparam logic [4:0] ST_CHECK    = 5'd4;
    localparam logic [4:0] ST_MISS     = 5'd5;
    localparam logic [4:0] ST_FREE     = 5'd6;
    localparam logic [4:0] ST_ALLOC    = 5'd7;
    localparam logic [4:0] ST_ZERO     = 5'd8;
    localparam logic [4:0] ST_LINK     = 5'd9;
    localparam logic [4:0] ST_FOLLOW   = 5'd10;
    localparam logic [4:0] ST_LEVEL    = 5'd11;
    localparam logic [4:0] ST_LEAF     = 5'd12;
    localparam logic [4:0] ST_LREAD    = 5'd13;
    localparam logic [4:0] ST_LCHK     = 5'd14;
    localparam logic [4:0] ST_LOK      = 5'd15;
    localparam logic [4:0] ST_WLEAF    = 5'd16;
    localparam logic [4:0] ST_FAIL_NM  = 5'd17;
    localparam logic [4:0] ST_FAIL_OOP = 5'd18;
    localparam logic [4:0] ST_POST     = 5'd19;
    localparam logic [4:0] ST_REPOST   = 5'd20;

    typedef struct packed {
        logic [3:0] op;
        logic [3:0] cond;
        logic [4:0] target;
    } ctl_t;

    // jump to target when cond holds, else fall through to step + 1
    function automatic ctl_t rom_word(input logic [4:0] step);
        ctl_t w;
        case (step)
            ST_CLEAR:    w = '{OP_CLEAR,   C_CLR_BUSY,  ST_CLEAR};
            ST_IDLE:     w = '{OP_TAKE,    C_NO_TAKE,   ST_IDLE};
            ST_ROOT:     w = '{OP_ROOT,    C_ROOT_BAD,  ST_FAIL_NM};
            ST_READ:     w = '{OP_READ,    C_NEXT,      ST_CHECK};
            ST_CHECK:    w = '{OP_NONE,    C_ENTRY_V,   ST_FOLLOW};
            ST_MISS:     w = '{OP_NONE,    C_LOOKUP,    ST_FAIL_NM};
            ST_FREE:     w = '{OP_NONE,    C_NO_FREE,   ST_FAIL_OOP};
            ST_ALLOC:    w = '{OP_ALLOC,   C_NEXT,      ST_ZERO};
            ST_ZERO:     w = '{OP_ZERO,    C_ZERO_BUSY, ST_ZERO};
            ST_LINK:     w = '{OP_LINK,    C_NEXT,      ST_FOLLOW};
            ST_FOLLOW:   w = '{OP_DESCEND, C_PTR_BAD,   ST_FAIL_NM};
            ST_LEVEL:    w = '{OP_NONE,    C_MORE_LVL,  ST_READ};
            ST_LEAF:     w = '{OP_NONE,    C_IS_MAP,    ST_WLEAF};
            ST_LREAD:    w = '{OP_READ,    C_NEXT,      ST_LCHK};
            ST_LCHK:     w = '{OP_NONE,    C_ENTRY_INV, ST_FAIL_NM};
            ST_LOK:      w = '{OP_SET_OK,  C_ALWAYS,    ST_POST};
            ST_WLEAF:    w = '{OP_WLEAF,   C_ALWAYS,    ST_POST};
            ST_FAIL_NM:  w = '{OP_SET_NM,  C_ALWAYS,    ST_POST};
            ST_FAIL_OOP: w = '{OP_SET_OOP, C_NEXT,      ST_POST};
            ST_POST:     w = '{OP_POST,    C_OUT_FREE,  ST_IDLE};
            ST_REPOST:   w = '{OP_NONE,    C_ALWAYS,    ST_POST};
            default:     w = '{OP_NONE,    C_ALWAYS,    ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* src/sv39_page_table_walker_unit.sv */
// ----------------------------------------------------------------------------
// sv39_page_table_walker_unit
// three-level sv39 page-table walker over a local table store
// ----------------------------------------------------------------------------
// Each input word is a lookup (tuser 0) or a map (tuser 1) of one virtual
// page; each gives exactly one result word with a status and, for a good
// lookup, the page base address. The tables live in an on-chip store of
// STORE_PAGES pages of 512 entries, addressed one entry per cycle through a
// single port. A small microcoded sequencer walks levels two and one, then
// reads or writes the leaf. After reset the sequencer sweeps the whole store
// to zero and takes no input word until done; configuration writes go
// through at any time. A new word is taken only once the last one has
// posted its result. Each missing node a map creates holds the walk while
// the single store port zeroes the new page one entry a cycle. The result
// sits in an output register, so the next word can be taken while it waits
// for m_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module sv39_page_table_walker_unit
    import sv39ptw_pkg::*;
#(
    parameter int STORE_PAGES = SV39PTW_STORE_PAGES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // virt_addr[38:0], phys_page[82:39], perm_flags[85:83], zero pad
    input  wire logic [87:0] s_tdata,
    // func[0]
    input  wire logic        s_tuser,

    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[1:0], phys_addr[57:2], zero pad
    output logic      [63:0] m_tdata,

    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic  [4:0] paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);

    localparam int PW    = (STORE_PAGES > 1) ? $clog2(STORE_PAGES) : 1;
    localparam int DEPTH = STORE_PAGES * ENTRIES_PER_TABLE;
    localparam int AW    = PW + IDX_W;

    localparam logic [12:0]      PAGES_13  = 13'(STORE_PAGES);
    localparam logic [PPN_W-1:0] PAGES_44  = PPN_W'(STORE_PAGES);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);

    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_ROOT  = 2'd1;
    localparam logic [1:0] REG_FIRST = 2'd2;

    localparam logic [1:0] LVL_2 = 2'd2;
    localparam logic [1:0] LVL_1 = 2'd1;
    localparam logic [1:0] LVL_0 = 2'd0;

    localparam logic [FREE_W-1:0] FREE_LIMIT = 7'd127;

    // sequencer
    logic [4:0]        step_reg, step_next;
    ctl_t              ctl;
    logic              cond_hit;

    // counters
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [IDX_W-1:0]  zero_cnt_reg, zero_cnt_next;

    // walk state
    logic [PW-1:0]     page_reg, page_next;
    logic [PW-1:0]     np_reg, np_next;
    logic [1:0]        lvl_reg, lvl_next;

    // request held during the walk
    logic              func_reg, func_next;
    logic [VA_W-1:0]   va_reg, va_next;
    logic [PPN_W-1:0]  ppn_reg, ppn_next;
    logic [2:0]        flags_reg, flags_next;

    // result staging and output register
    logic [1:0]        status_reg, status_next;
    logic [55:0]       phys_reg, phys_next;
    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_status_reg, m_status_next;
    logic [55:0]       m_phys_reg, m_phys_next;

    // configuration
    logic [PPN_W-1:0]  base_reg, base_next;
    logic [5:0]        root_reg, root_next;
    logic [FREE_W-1:0] first_reg, first_next;
    logic [FREE_W-1:0] next_free_reg, next_free_next;

    // store port
    logic               mem_we, mem_re, mem_fwd;
    logic [AW-1:0]      mem_addr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ENTRY_W-1:0] entry;

    // datapath helpers
    logic [IDX_W-1:0]  idx;
    logic [AW-1:0]     walk_addr;
    logic [PPN_W-1:0]  rel;
    logic [PPN_W-1:0]  new_ppn;
    logic              in_acc;
    logic              out_free;
    logic              cfg_wr;
    logic              root_bad;
    logic              ptr_bad;
    logic              no_free;

    sv39ptw_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .fwd   (mem_fwd),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (entry)
    );

    assign ctl      = rom_word(step_reg);
    assign s_tready = (ctl.op == OP_TAKE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    // table index of the current level
    always_comb begin
        case (lvl_reg)
            LVL_2:   idx = va_reg[38:30];
            LVL_1:   idx = va_reg[29:21];
            default: idx = va_reg[20:12];
        endcase
    end

    assign walk_addr = {page_reg, idx};
    assign rel       = entry[53:10] - base_reg;
    assign new_ppn   = base_reg + PPN_W'(np_reg);
    assign root_bad  = {7'd0, root_reg} >= PAGES_13;
    assign ptr_bad   = rel >= PAGES_44;
    assign no_free   = ({6'd0, next_free_reg} >= PAGES_13) || (next_free_reg == FREE_LIMIT);

    // branch condition
    always_comb begin
        case (ctl.cond)
            C_NEXT:      cond_hit = 1'b0;
            C_ALWAYS:    cond_hit = 1'b1;
            C_CLR_BUSY:  cond_hit = clr_cnt_reg != LAST_ADDR;
            C_NO_TAKE:   cond_hit = !in_acc;
            C_ROOT_BAD:  cond_hit = root_bad;
            C_ENTRY_V:   cond_hit = entry[0];
            C_LOOKUP:    cond_hit = !func_reg;
            C_NO_FREE:   cond_hit = no_free;
            C_ZERO_BUSY: cond_hit = zero_cnt_reg != {IDX_W{1'b1}};
            C_PTR_BAD:   cond_hit = ptr_bad;
            C_MORE_LVL:  cond_hit = lvl_reg != LVL_0;
            C_IS_MAP:    cond_hit = func_reg;
            C_ENTRY_INV: cond_hit = !entry[0];
            C_OUT_FREE:  cond_hit = out_free;
            default:     cond_hit = 1'b0;
        endcase
    end

    assign step_next = cond_hit ? ctl.target : step_reg + 5'd1;

    // datapath driven by the control word
    always_comb begin
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_fwd        = 1'b0;
        mem_addr       = walk_addr;
        mem_wdata      = '0;
        clr_cnt_next   = clr_cnt_reg;
        zero_cnt_next  = zero_cnt_reg;
        page_next      = page_reg;
        np_next        = np_reg;
        lvl_next       = lvl_reg;
        func_next      = func_reg;
        va_next        = va_reg;
        ppn_next       = ppn_reg;
        flags_next     = flags_reg;
        status_next    = status_reg;
        phys_next      = phys_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_status_next  = m_status_reg;
        m_phys_next    = m_phys_reg;
        next_free_next = next_free_reg;

        case (ctl.op)
            OP_CLEAR: begin
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
            OP_TAKE: begin
                if (in_acc) begin
                    func_next  = s_tuser;
                    va_next    = s_tdata[38:0];
                    ppn_next   = s_tdata[82:39];
                    flags_next = s_tdata[85:83];
                end
            end
            OP_ROOT: begin
                page_next = PW'(root_reg);
                lvl_next  = LVL_2;
            end
            OP_READ: begin
                mem_re = 1'b1;
            end
            OP_ALLOC: begin
                np_next        = PW'(next_free_reg);
                next_free_next = next_free_reg + 7'd1;
                zero_cnt_next  = '0;
            end
            OP_ZERO: begin
                mem_we        = 1'b1;
                mem_addr      = {np_reg, zero_cnt_reg};
                zero_cnt_next = zero_cnt_reg + 9'd1;
            end
            OP_LINK: begin
                // V-only pointer to the fresh page
                mem_we    = 1'b1;
                mem_fwd   = 1'b1;
                mem_wdata = {10'd0, new_ppn, 9'd0, 1'b1};
            end
            OP_DESCEND: begin
                page_next = PW'(rel);
                lvl_next  = lvl_reg - 2'd1;
            end
            OP_SET_OK: begin
                status_next = STAT_OK;
                phys_next   = {entry[53:10], 12'd0};
            end
            OP_WLEAF: begin
                // leaf: V and R always, W X U from the flags
                mem_we      = 1'b1;
                mem_wdata   = {10'd0, ppn_reg, 5'd0, flags_reg, 2'b11};
                status_next = STAT_OK;
                phys_next   = '0;
            end
            OP_SET_NM: begin
                status_next = STAT_NOT_MAPPED;
                phys_next   = '0;
            end
            OP_SET_OOP: begin
                status_next = STAT_NO_PAGES;
                phys_next   = '0;
            end
            OP_POST: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_phys_next   = phys_reg;
                end
            end
            default: begin
            end
        endcase

        if (cfg_wr && paddr[4:3] == REG_FIRST) begin
            next_free_next = pwdata[6:0];
        end
    end

    // configuration registers
    always_comb begin
        base_next  = base_reg;
        root_next  = root_reg;
        first_next = first_reg;
        if (cfg_wr) begin
            case (paddr[4:3])
                REG_BASE:  base_next  = pwdata[43:0];
                REG_ROOT:  root_next  = pwdata[5:0];
                REG_FIRST: first_next = pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_BASE:  prdata = {20'd0, base_reg};
            REG_ROOT:  prdata = {58'd0, root_reg};
            REG_FIRST: prdata = {57'd0, first_reg};
            default:   prdata = '0;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
            base_reg      <= '0;
            root_reg      <= '0;
            first_reg     <= 7'd1;
            next_free_reg <= 7'd1;
        end else begin
            step_reg      <= step_next;
            clr_cnt_reg   <= clr_cnt_next;
            m_valid_reg   <= m_valid_next;
            base_reg      <= base_next;
            root_reg      <= root_next;
            first_reg     <= first_next;
            next_free_reg <= next_free_next;
        end
    end

    // walk and payload registers
    always_ff @(posedge aclk) begin
        zero_cnt_reg <= zero_cnt_next;
        page_reg     <= page_next;
        np_reg       <= np_next;
        lvl_reg      <= lvl_next;
        func_reg     <= func_next;
        va_reg       <= va_next;
        ppn_reg      <= ppn_next;
        flags_reg    <= flags_next;
        status_reg   <= status_next;
        phys_reg     <= phys_next;
        m_status_reg <= m_status_next;
        m_phys_reg   <= m_phys_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_phys_reg, m_status_reg};

    // a page is handed out only while one is left
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.op == OP_ALLOC) |-> !no_free)
    else $error("page allocated with none left");

    // no word taken until the store sweep has finished
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == ST_CLEAR) |-> !s_tready)
    else $error("input taken during store clear");

    // a pending result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("pending result lost");

    // the store is never written while waiting for a word or a result slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == ST_IDLE || step_reg == ST_POST) |-> !mem_we)
    else $error("store written outside the walk");

    // status always one of the defined codes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
    else $error("undefined result status");

endmodule

`default_nettype wire

/* src/sv39ptw_store.sv */
// ----------------------------------------------------------------------------
// sv39ptw_store
// single-port table store with registered read and write forwarding
// ----------------------------------------------------------------------------
`default_nettype none

module sv39ptw_store
    import sv39ptw_pkg::*;
#(
    parameter int DEPTH = SV39PTW_STORE_PAGES * ENTRIES_PER_TABLE,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic               aclk,
    input  wire logic               we,
    input  wire logic               re,
    input  wire logic               fwd,
    input  wire logic [AW-1:0]      addr,
    input  wire logic [ENTRY_W-1:0] wdata,
    output logic      [ENTRY_W-1:0] rdata
);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
    end

    // a forwarded write also becomes the current entry
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[addr];
        end else if (we && fwd) begin
            rdata_reg <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
